// ===== design/pipat_pkg.sv =====
// shared types, widths and helpers for the point in polygon area test
package pipat_pkg;

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SPROD_W  = 2 * COORD_W;
    localparam int TPROD_W  = 2 * DIFF_W;
    localparam int SCROSS_W = SPROD_W + 1;
    localparam int TCROSS_W = TPROD_W + 1;
    localparam int ACC_W    = 48;
    localparam int AREA_W   = 33;

    // vertex count codes, saturating at three
    localparam logic [1:0] CNT_IDLE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_MAX  = 2'd3;

    localparam logic [ACC_W-1:0] AREA_MAX = {{(ACC_W - AREA_W){1'b0}}, {AREA_W{1'b1}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [SPROD_W-1:0] sprod_t;
    typedef logic signed [TPROD_W-1:0] tprod_t;

    typedef struct packed {
        logic       last;
        logic       restart;
        logic       edge_en;
        logic [1:0] count;
        logic       hit;
    } ctrl_t;

    // edge a->b, closing edge b->f, query p
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t fx;
        coord_t fy;
        coord_t px;
        coord_t py;
        ctrl_t  ctrl;
    } edge_job_t;

    function automatic diff_t sub_c(input coord_t a, input coord_t b);
        diff_t r;
        r = DIFF_W'(a) - DIFF_W'(b);
        return r;
    endfunction

    function automatic sprod_t mul_s(input coord_t a, input coord_t b);
        sprod_t r;
        r = SPROD_W'(a) * SPROD_W'(b);
        return r;
    endfunction

    function automatic tprod_t mul_t(input diff_t a, input diff_t b);
        tprod_t r;
        r = TPROD_W'(a) * TPROD_W'(b);
        return r;
    endfunction

endpackage

// ===== design/pipat_sums.sv =====
// product stage and accumulator stage for the shoelace and triangle sums
module pipat_sums
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        job_valid,
    input  pipat_pkg::edge_job_t        job,
    output logic                        sum_valid,
    output pipat_pkg::ctrl_t            sum_ctrl,
    output logic [pipat_pkg::ACC_W-1:0] shoe_sum,
    output logic [pipat_pkg::ACC_W-1:0] tri_sum
);

    // product stage
    logic                  b_valid_reg;
    pipat_pkg::ctrl_t      b_ctrl_reg;
    pipat_pkg::sprod_t     s1a_reg, s1b_reg, s2a_reg, s2b_reg;
    pipat_pkg::tprod_t     t1a_reg, t1b_reg, t2a_reg, t2b_reg;

    // accumulator stage
    logic                  c_valid_reg;
    pipat_pkg::ctrl_t      c_ctrl_reg;
    logic [pipat_pkg::ACC_W-1:0] shoe_reg, shoe_next;
    logic [pipat_pkg::ACC_W-1:0] tri_reg, tri_next;

    pipat_pkg::diff_t dax, day, dbx, dby, dfx, dfy;

    logic signed [pipat_pkg::SCROSS_W-1:0] s1, s2;
    logic signed [pipat_pkg::TCROSS_W-1:0] t1, t2;
    logic        [pipat_pkg::TCROSS_W-1:0] t1_abs, t2_abs;
    logic        [pipat_pkg::ACC_W-1:0]    shoe_base, tri_base;
    logic        [pipat_pkg::ACC_W-1:0]    s1_ext, s2_ext, t1_ext, t2_ext;

    assign dax = pipat_pkg::sub_c(job.ax, job.px);
    assign day = pipat_pkg::sub_c(job.ay, job.py);
    assign dbx = pipat_pkg::sub_c(job.bx, job.px);
    assign dby = pipat_pkg::sub_c(job.by, job.py);
    assign dfx = pipat_pkg::sub_c(job.fx, job.px);
    assign dfy = pipat_pkg::sub_c(job.fy, job.py);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && job_valid)
        begin
            b_ctrl_reg <= job.ctrl;
            s1a_reg    <= pipat_pkg::mul_s(job.ax, job.by);
            s1b_reg    <= pipat_pkg::mul_s(job.ay, job.bx);
            t1a_reg    <= pipat_pkg::mul_t(dax, dby);
            t1b_reg    <= pipat_pkg::mul_t(dbx, day);
            s2a_reg    <= pipat_pkg::mul_s(job.bx, job.fy);
            s2b_reg    <= pipat_pkg::mul_s(job.by, job.fx);
            t2a_reg    <= pipat_pkg::mul_t(dbx, dfy);
            t2b_reg    <= pipat_pkg::mul_t(dfx, dby);
        end
    end

    always_comb
    begin
        s1 = pipat_pkg::SCROSS_W'(s1a_reg) - pipat_pkg::SCROSS_W'(s1b_reg);
        s2 = pipat_pkg::SCROSS_W'(s2a_reg) - pipat_pkg::SCROSS_W'(s2b_reg);
        t1 = pipat_pkg::TCROSS_W'(t1a_reg) - pipat_pkg::TCROSS_W'(t1b_reg);
        t2 = pipat_pkg::TCROSS_W'(t2a_reg) - pipat_pkg::TCROSS_W'(t2b_reg);

        t1_abs = t1[pipat_pkg::TCROSS_W-1] ? pipat_pkg::TCROSS_W'(-t1)
                                           : pipat_pkg::TCROSS_W'(t1);
        t2_abs = t2[pipat_pkg::TCROSS_W-1] ? pipat_pkg::TCROSS_W'(-t2)
                                           : pipat_pkg::TCROSS_W'(t2);

        // edge from previous vertex only once a polygon is open
        s1_ext = b_ctrl_reg.edge_en ? pipat_pkg::ACC_W'(s1) : '0;
        t1_ext = b_ctrl_reg.edge_en ? pipat_pkg::ACC_W'(t1_abs) : '0;
        // closing edge only on the last beat
        s2_ext = b_ctrl_reg.last ? pipat_pkg::ACC_W'(s2) : '0;
        t2_ext = b_ctrl_reg.last ? pipat_pkg::ACC_W'(t2_abs) : '0;

        shoe_base = b_ctrl_reg.restart ? '0 : shoe_reg;
        tri_base  = b_ctrl_reg.restart ? '0 : tri_reg;

        shoe_next = shoe_base + s1_ext + s2_ext;
        tri_next  = tri_base + t1_ext + t2_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            c_ctrl_reg <= b_ctrl_reg;
            shoe_reg   <= shoe_next;
            tri_reg    <= tri_next;
        end
    end

    assign sum_valid = c_valid_reg;
    assign sum_ctrl  = c_ctrl_reg;
    assign shoe_sum  = shoe_reg;
    assign tri_sum   = tri_reg;

    // a restart beat never carries the edge from a previous vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> !(b_ctrl_reg.restart && b_ctrl_reg.edge_en))
        else $error("restart beat with open edge");

    // accumulator holds while the pipeline is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(shoe_reg) && $stable(tri_reg))
        else $error("sums moved during stall");

    // a restart beat reaching the accumulator starts from its own edges only
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && b_valid_reg && b_ctrl_reg.restart && !b_ctrl_reg.last)
        |=> tri_reg == '0)
        else $error("triangle sum not cleared on new polygon");

endmodule

// ===== design/point_in_polygon_area_test.sv =====
// top level: streamed point in polygon test by integer area sums
// a vertex beat accepted into the input stage passes the product and accumulator stages to the result register
// throughput: one vertex beat per cycle while no result waits on out_ready; one result beat per polygon
// the whole pipeline advances together; it holds only while a result waits on out_ready
// reset (rst_n, async, active low) empties every stage and leaves no polygon open
module point_in_polygon_area_test
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            vertex_x,
    input  logic signed [15:0]            vertex_y,
    input  logic signed [15:0]            query_x,
    input  logic signed [15:0]            query_y,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    output logic                          on_vertex,
    output logic [pipat_pkg::AREA_W-1:0]  twice_area
);

    // pipeline moves when the result register is empty or being drained
    logic advance;
    logic accept;

    // polygon tracking state
    logic [1:0]        cnt_reg, cnt_next;
    logic              hit_reg;
    pipat_pkg::coord_t first_x_reg, first_y_reg;
    pipat_pkg::coord_t prev_x_reg, prev_y_reg;
    pipat_pkg::coord_t point_x_reg, point_y_reg;

    // per-beat decode
    logic              new_poly;
    logic              hit_now;
    logic              hit_next;
    pipat_pkg::coord_t first_x, first_y;
    pipat_pkg::coord_t point_x, point_y;

    // input stage
    logic                 a_valid_reg;
    pipat_pkg::edge_job_t job_reg, job_next;

    // accumulator outputs
    logic                          sum_valid;
    pipat_pkg::ctrl_t              sum_ctrl;
    logic [pipat_pkg::ACC_W-1:0]   shoe_sum;
    logic [pipat_pkg::ACC_W-1:0]   tri_sum;

    // result stage
    logic                          out_valid_reg;
    logic                          inside_res_reg, inside_res_next;
    logic                          on_vertex_reg;
    logic [pipat_pkg::AREA_W-1:0]  twice_area_reg, twice_area_next;
    logic [pipat_pkg::ACC_W-1:0]   shoe_abs;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    // first beat of a polygon latches the query and first vertex
    always_comb
    begin
        new_poly = (cnt_reg == pipat_pkg::CNT_IDLE);
        point_x  = new_poly ? query_x  : point_x_reg;
        point_y  = new_poly ? query_y  : point_y_reg;
        first_x  = new_poly ? vertex_x : first_x_reg;
        first_y  = new_poly ? vertex_y : first_y_reg;
        hit_now  = (vertex_x == point_x) && (vertex_y == point_y);
        hit_next = (!new_poly && hit_reg) || hit_now;

        unique case (cnt_reg)
            pipat_pkg::CNT_IDLE: cnt_next = pipat_pkg::CNT_ONE;
            pipat_pkg::CNT_ONE:  cnt_next = pipat_pkg::CNT_TWO;
            pipat_pkg::CNT_TWO:  cnt_next = pipat_pkg::CNT_MAX;
            default:             cnt_next = pipat_pkg::CNT_MAX;
        endcase

        job_next.ax           = prev_x_reg;
        job_next.ay           = prev_y_reg;
        job_next.bx           = vertex_x;
        job_next.by           = vertex_y;
        job_next.fx           = first_x;
        job_next.fy           = first_y;
        job_next.px           = point_x;
        job_next.py           = point_y;
        job_next.ctrl.last    = last_vertex;
        job_next.ctrl.restart = new_poly;
        job_next.ctrl.edge_en = !new_poly;
        job_next.ctrl.count   = cnt_next;
        job_next.ctrl.hit     = hit_next;
    end

    // polygon control state; a last beat closes the polygon
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= pipat_pkg::CNT_IDLE;
            hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg <= last_vertex ? pipat_pkg::CNT_IDLE : cnt_next;
            hit_reg <= last_vertex ? 1'b0 : hit_next;
        end
    end

    // polygon coordinates: first vertex and query change on a first beat, previous vertex on every beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_x_reg <= first_x;
            first_y_reg <= first_y;
            point_x_reg <= point_x;
            point_y_reg <= point_y;
            prev_x_reg  <= vertex_x;
            prev_y_reg  <= vertex_y;
            job_reg     <= job_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // products then running sums
    pipat_sums u_sums
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .job_valid (a_valid_reg),
        .job       (job_reg),
        .sum_valid (sum_valid),
        .sum_ctrl  (sum_ctrl),
        .shoe_sum  (shoe_sum),
        .tri_sum   (tri_sum)
    );

    // final compare: with three or more vertices, absolute shoelace sum against the triangle sum
    always_comb
    begin
        shoe_abs = shoe_sum[pipat_pkg::ACC_W-1] ? (~shoe_sum + 1'b1) : shoe_sum;

        unique case (sum_ctrl.count)
            pipat_pkg::CNT_MAX:
            begin
                inside_res_next = sum_ctrl.hit || (shoe_abs == tri_sum);
                twice_area_next = (shoe_abs > pipat_pkg::AREA_MAX)
                                ? pipat_pkg::AREA_MAX[pipat_pkg::AREA_W-1:0]
                                : shoe_abs[pipat_pkg::AREA_W-1:0];
            end
            pipat_pkg::CNT_TWO:
            begin
                // two vertices: inside only on the line through them
                inside_res_next = sum_ctrl.hit || (tri_sum == '0);
                twice_area_next = '0;
            end
            default:
            begin
                // single vertex: only a vertex match counts
                inside_res_next = sum_ctrl.hit;
                twice_area_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= sum_valid && sum_ctrl.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sum_valid && sum_ctrl.last)
        begin
            inside_res_reg <= inside_res_next;
            on_vertex_reg  <= sum_ctrl.hit;
            twice_area_reg <= twice_area_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;
    assign on_vertex  = on_vertex_reg;
    assign twice_area = twice_area_reg;

    // a closing beat leaves the block with no polygon open
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_vertex) |=> cnt_reg == pipat_pkg::CNT_IDLE)
        else $error("polygon still open after last beat");

    // vertex count saturates at three
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_vertex && cnt_reg == pipat_pkg::CNT_MAX)
        |=> cnt_reg == pipat_pkg::CNT_MAX)
        else $error("vertex count left saturation");

    // a query on a vertex is always reported inside
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && on_vertex) |-> inside_res)
        else $error("vertex hit reported outside");

    // with no result waiting the block always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

// ===== tb/point_in_polygon_area_test_tb.sv =====
// testbench for the streamed point in polygon area test, with its own predictor and checker
module point_in_polygon_area_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // one result beat as the block should produce it
    typedef struct packed {
        logic                        in_poly;
        logic                        on_vtx;
        logic [pipat_pkg::AREA_W-1:0] area;
    } area_result_t;

    // polygon shapes used by the random part
    typedef enum int {
        SHAPE_TRIANGLE,
        SHAPE_RECT,
        SHAPE_WILD,
        SHAPE_TINY,
        SHAPE_LONG
    } shape_t;

    localparam int RUN_LIMIT_NS   = 4_000_000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int CALM_ITEMS     = 300;
    localparam int WRAP_PASSES    = 40;
    localparam int MAX_REPORTS    = 20;
    localparam int TAIL_CYCLES    = 10;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // vertex side
    logic              in_valid    = 1'b0;
    logic              in_ready;
    pipat_pkg::coord_t vertex_x    = '0;
    pipat_pkg::coord_t vertex_y    = '0;
    pipat_pkg::coord_t query_x     = '0;
    pipat_pkg::coord_t query_y     = '0;
    logic              last_vertex = 1'b0;

    // result side
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         inside_res;
    logic                         on_vertex;
    logic [pipat_pkg::AREA_W-1:0] twice_area;

    point_in_polygon_area_test u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .query_x     (query_x),
        .query_y     (query_y),
        .last_vertex (last_vertex),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .inside_res  (inside_res),
        .on_vertex   (on_vertex),
        .twice_area  (twice_area)
    );

    // results still owed by the block, oldest first
    area_result_t pending_results[$];

    // predictor state for the polygon being streamed
    longint                      poly_fx, poly_fy;     // first vertex
    longint                      poly_lx, poly_ly;     // previous vertex
    longint                      poly_qx, poly_qy;     // query latched on the first beat
    logic [pipat_pkg::ACC_W-1:0] shoelace_acc = '0;    // signed shoelace sum, wraps at acc width
    logic [pipat_pkg::ACC_W-1:0] triangle_acc = '0;    // sum of absolute triangle cross products
    int                          poly_len     = 0;     // vertices seen, saturates at three
    bit                          poly_hit     = 1'b0;

    // run bookkeeping
    bit idle_on     = 1'b1;
    int stall_left  = 0;
    int mismatches  = 0;
    int items_sent  = 0;
    int polys_sent  = 0;
    int results_ok  = 0;
    int inside_seen = 0;
    int sat_seen    = 0;

    // polygon under construction for send_polygon
    pipat_pkg::coord_t poly_x[$];
    pipat_pkg::coord_t poly_y[$];

    // one edge a->b into both sums; products fit easily in 64 bits
    function automatic void add_edge_terms(longint ax, longint ay, longint bx, longint by);
        longint cross_term;
        longint tri_term;
        cross_term = ax * by - ay * bx;
        tri_term   = (ax - poly_qx) * (by - poly_qy) - (bx - poly_qx) * (ay - poly_qy);
        if (tri_term < 0)
            tri_term = -tri_term;
        shoelace_acc = shoelace_acc + cross_term[pipat_pkg::ACC_W-1:0];
        triangle_acc = triangle_acc + tri_term[pipat_pkg::ACC_W-1:0];
    endfunction

    // advance the polygon state by one accepted vertex beat, queue a result on the last one
    function automatic void predict_vertex(pipat_pkg::coord_t vx, pipat_pkg::coord_t vy,
                                           pipat_pkg::coord_t qx, pipat_pkg::coord_t qy,
                                           logic is_last);
        longint       sx;
        longint       sy;
        longint       signed_sum;
        logic [63:0]  mag;
        bit           match;
        area_result_t res;
        sx = vx;
        sy = vy;
        if (poly_len == 0)
        begin
            // opening beat: first vertex and query latched, sums cleared
            poly_fx      = sx;
            poly_fy      = sy;
            poly_qx      = qx;
            poly_qy      = qy;
            shoelace_acc = '0;
            triangle_acc = '0;
            poly_hit     = 1'b0;
            poly_len     = 1;
        end
        else
        begin
            add_edge_terms(poly_lx, poly_ly, sx, sy);
            if (poly_len < 3)
                poly_len++;
        end
        if (sx == poly_qx && sy == poly_qy)
            poly_hit = 1'b1;
        poly_lx = sx;
        poly_ly = sy;
        if (is_last)
        begin
            // closing edge back to the first vertex
            add_edge_terms(sx, sy, poly_fx, poly_fy);
            signed_sum = {{(64 - pipat_pkg::ACC_W){shoelace_acc[pipat_pkg::ACC_W-1]}},
                          shoelace_acc};
            mag        = (signed_sum < 0) ? -signed_sum : signed_sum;
            match      = 1'b0;
            res.area   = '0;
            if (poly_len >= 3)
            begin
                // exact compare on the full accumulator, saturation only on the output
                match    = (mag == 64'(triangle_acc));
                res.area = (mag > 64'(pipat_pkg::AREA_MAX)) ? {pipat_pkg::AREA_W{1'b1}}
                                                            : mag[pipat_pkg::AREA_W-1:0];
            end
            else if (poly_len == 2)
                match = (triangle_acc == '0);
            res.on_vtx  = poly_hit;
            res.in_poly = poly_hit | match;
            pending_results.push_back(res);
            poly_len = 0;
        end
    endfunction

    function automatic pipat_pkg::coord_t rand_coord();
        return pipat_pkg::coord_t'($urandom);
    endfunction

    function automatic pipat_pkg::coord_t tiny_coord();
        return pipat_pkg::coord_t'(int'($urandom_range(0, 8)) - 4);
    endfunction

    // drive one vertex beat and hold it until the block takes it
    task automatic send_vertex(pipat_pkg::coord_t vx, pipat_pkg::coord_t vy,
                               pipat_pkg::coord_t qx, pipat_pkg::coord_t qy, logic is_last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            // sender gap burst
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        vertex_x    <= vx;
        vertex_y    <= vy;
        query_x     <= qx;
        query_y     <= qy;
        last_vertex <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_vertex(vx, vy, qx, qy, is_last);
        items_sent++;
    endtask

    // stream poly_x/poly_y as one polygon; query fields after the first beat are noise
    task automatic send_polygon(pipat_pkg::coord_t qx, pipat_pkg::coord_t qy);
        int n;
        n = poly_x.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                send_vertex(poly_x[i], poly_y[i], qx, qy, n == 1);
            else
                send_vertex(poly_x[i], poly_y[i], rand_coord(), rand_coord(), i == n - 1);
        end
        polys_sent++;
    endtask

    task automatic add_vertex(pipat_pkg::coord_t x, pipat_pkg::coord_t y);
        poly_x.push_back(x);
        poly_y.push_back(y);
    endtask

    // drop valid and hold off until every owed result has come out
    task automatic wait_for_results();
        if (pending_results.size() != 0)
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // lone vertex: only an exact match on the query counts
    task automatic test_single_vertex();
        poly_x = {}; poly_y = {};
        add_vertex(-16'sd32768, 16'sd32767);
        send_polygon(-16'sd32768, 16'sd32767);
        poly_x = {}; poly_y = {};
        add_vertex(16'sd32767, -16'sd32768);
        send_polygon(-16'sd1, 16'sd0);
    endtask

    // segment: zero area, inside when the query sits on the line through it
    task automatic test_two_vertices();
        poly_x = {}; poly_y = {};
        add_vertex(16'sd0, 16'sd0);
        add_vertex(16'sd4, 16'sd4);
        send_polygon(-16'sd3, -16'sd3);
        poly_x = {}; poly_y = {};
        add_vertex(16'sd0, 16'sd0);
        add_vertex(16'sd4, 16'sd4);
        send_polygon(16'sd1, 16'sd2);
    endtask

    // small triangles in both windings, query inside and on a vertex
    task automatic test_triangles();
        poly_x = {}; poly_y = {};
        add_vertex(16'sd0, 16'sd0);
        add_vertex(16'sd10, 16'sd0);
        add_vertex(16'sd0, 16'sd10);
        send_polygon(16'sd2, 16'sd2);
        poly_x = {}; poly_y = {};
        add_vertex(16'sd0, 16'sd0);
        add_vertex(16'sd0, 16'sd10);
        add_vertex(16'sd10, 16'sd0);
        send_polygon(16'sd10, 16'sd0);
    endtask

    // full-range square, query on an edge: largest area a simple polygon can have
    task automatic test_extreme_square();
        poly_x = {}; poly_y = {};
        add_vertex(-16'sd32768, -16'sd32768);
        add_vertex(16'sd32767, -16'sd32768);
        add_vertex(16'sd32767, 16'sd32767);
        add_vertex(-16'sd32768, 16'sd32767);
        send_polygon(-16'sd32768, 16'sd0);
    endtask

    // square walked twice: area output saturates, compare still on full sums
    task automatic test_area_saturation();
        poly_x = {}; poly_y = {};
        repeat (2)
        begin
            add_vertex(-16'sd32768, -16'sd32768);
            add_vertex(16'sd32767, -16'sd32768);
            add_vertex(16'sd32767, 16'sd32767);
            add_vertex(-16'sd32768, 16'sd32767);
        end
        send_polygon(16'sd0, 16'sd0);
    endtask

    // square walked many times back to back: sums run far past the area output width
    task automatic test_long_wrap();
        bit saved;
        saved   = idle_on;
        idle_on = 1'b0;
        poly_x = {}; poly_y = {};
        add_vertex(-16'sd32768, -16'sd32768);
        add_vertex(16'sd32767, -16'sd32768);
        add_vertex(16'sd32767, 16'sd32767);
        add_vertex(-16'sd32768, 16'sd32767);
        for (int p = 0; p < WRAP_PASSES; p++)
            for (int k = 0; k < 4; k++)
                send_vertex(poly_x[k], poly_y[k], 16'sd0, 16'sd0,
                            p == WRAP_PASSES - 1 && k == 3);
        polys_sent++;
        idle_on = saved;
    endtask

    // one random polygon of a random shape
    task automatic send_random_polygon();
        shape_t            shape;
        int                r;
        int                n;
        int                start;
        int                idx;
        bit                ccw;
        pipat_pkg::coord_t a, b, lo_x, hi_x, lo_y, hi_y, qx, qy;
        pipat_pkg::coord_t cx[4];
        pipat_pkg::coord_t cy[4];
        r = $urandom_range(0, 99);
        if (r < 25)
            shape = SHAPE_TRIANGLE;
        else if (r < 50)
            shape = SHAPE_RECT;
        else if (r < 75)
            shape = SHAPE_WILD;
        else if (r < 95)
            shape = SHAPE_TINY;
        else
            shape = SHAPE_LONG;
        poly_x = {}; poly_y = {};
        qx = rand_coord();
        qy = rand_coord();
        case (shape)
            SHAPE_TRIANGLE:
            begin
                // centroid is inside unless the triangle is degenerate or rounding bites
                repeat (3) add_vertex(rand_coord(), rand_coord());
                qx = pipat_pkg::coord_t'((int'(poly_x[0]) + int'(poly_x[1])
                                          + int'(poly_x[2])) / 3);
                qy = pipat_pkg::coord_t'((int'(poly_y[0]) + int'(poly_y[1])
                                          + int'(poly_y[2])) / 3);
            end
            SHAPE_RECT:
            begin
                a = rand_coord(); b = rand_coord();
                lo_x = (a < b) ? a : b; hi_x = (a < b) ? b : a;
                a = rand_coord(); b = rand_coord();
                lo_y = (a < b) ? a : b; hi_y = (a < b) ? b : a;
                cx = '{lo_x, hi_x, hi_x, lo_x};
                cy = '{lo_y, lo_y, hi_y, hi_y};
                start = $urandom_range(0, 3);
                ccw   = $urandom_range(0, 1);
                for (int k = 0; k < 4; k++)
                begin
                    idx = ccw ? (start + k) % 4 : (start + 4 - k) % 4;
                    add_vertex(cx[idx], cy[idx]);
                end
                // within the box for half the queries, right on its border for a quarter, else anywhere
                r = $urandom_range(0, 3);
                if (r == 0)
                begin
                    qx = $urandom_range(0, 1) ? lo_x : hi_x;
                    qy = pipat_pkg::coord_t'(int'(lo_y)
                         + int'($urandom_range(0, int'(hi_y) - int'(lo_y))));
                end
                else if (r != 3)
                begin
                    qx = pipat_pkg::coord_t'(int'(lo_x)
                         + int'($urandom_range(0, int'(hi_x) - int'(lo_x))));
                    qy = pipat_pkg::coord_t'(int'(lo_y)
                         + int'($urandom_range(0, int'(hi_y) - int'(lo_y))));
                end
            end
            SHAPE_WILD:
            begin
                n = $urandom_range(1, 8);
                repeat (n) add_vertex(rand_coord(), rand_coord());
                if ($urandom_range(0, 2) == 0)
                begin
                    idx = $urandom_range(0, n - 1);
                    qx  = poly_x[idx];
                    qy  = poly_y[idx];
                end
            end
            SHAPE_TINY:
            begin
                // small grid: collinear points, shared vertices and edge hits are common
                n = $urandom_range(1, 6);
                repeat (n) add_vertex(tiny_coord(), tiny_coord());
                qx = tiny_coord();
                qy = tiny_coord();
            end
            default:
            begin
                n = $urandom_range(20, 60);
                repeat (n) add_vertex(tiny_coord(), tiny_coord());
                qx = tiny_coord();
                qy = tiny_coord();
            end
        endcase
        send_polygon(qx, qy);
    endtask

    task automatic test_random_polygons();
        int base;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS - CALM_ITEMS)
        begin
            send_random_polygon();
            // past midway, on every fiftieth polygon, hold off until the block has drained completely
            if (items_sent - base >= (RANDOM_ITEMS - CALM_ITEMS) / 2 && idle_on
                && polys_sent % 50 == 0)
                wait_for_results();
        end
        wait_for_results();
        // last stretch at full rate on both sides
        idle_on = 1'b0;
        base    = items_sent;
        while (items_sent - base < CALM_ITEMS)
            send_random_polygon();
    endtask

    // ---------------------------------------------------------------- result side

    // result consumer: random stall bursts while idling is enabled
    always @(posedge clk)
    begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic flag_mismatch(string what, longint want_v, longint got_v);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
        mismatches++;
    endtask

    // compare every result beat against the oldest outstanding prediction
    always @(posedge clk)
    begin : result_check
        area_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result beat with nothing expected, inside %0d area %0d",
                             $time, inside_res, twice_area);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (inside_res !== want.in_poly)
                    flag_mismatch("inside_res", want.in_poly, inside_res);
                if (on_vertex !== want.on_vtx)
                    flag_mismatch("on_vertex", want.on_vtx, on_vertex);
                if (twice_area !== want.area)
                    flag_mismatch("twice_area", want.area, twice_area);
                results_ok++;
                if (want.in_poly)
                    inside_seen++;
                if (want.area == {pipat_pkg::AREA_W{1'b1}})
                    sat_seen++;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_vertex();
        test_two_vertices();
        test_triangles();
        test_extreme_square();
        test_area_saturation();
        test_long_wrap();
        test_random_polygons();

        wait_for_results();
        // let any stray beat surface past the input, product, accumulator and result stages
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d polygons over %0d vertex beats, %0d results checked",
                 polys_sent, items_sent, results_ok);
        $display("results inside %0d, saturated area %0d, mismatches %0d",
                 inside_seen, sat_seen, mismatches);
        if (mismatches == 0)
            $display("point_in_polygon_area_test_tb OK");
        else
            $display("point_in_polygon_area_test_tb NOT OK");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("point_in_polygon_area_test_tb NOT OK");
        $finish;
    end

endmodule
